// ===== rtl/msa_pkg.sv =====
package msa_pkg;

  localparam int ARENA_BYTES = 65536;
  localparam int MAX_MARKERS = 64;

  localparam int OFS_W   = 17;
  localparam int ADDR_W  = 32;
  localparam int MSZ_W   = 4;
  localparam int DEPTH_W = $clog2(MAX_MARKERS + 1);
  localparam int STK_AW  = $clog2(MAX_MARKERS);
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_ARENA_BASE  = 2'd0;
  localparam logic [1:0] REG_ARENA_SIZE  = 2'd1;
  localparam logic [1:0] REG_MARKER_SIZE = 2'd2;

  localparam logic [ADDR_W-1:0] ARENA_BASE_RST  = '0;
  localparam logic [OFS_W-1:0]  ARENA_SIZE_RST  = OFS_W'(65536);
  localparam logic [MSZ_W-1:0]  MARKER_SIZE_RST = MSZ_W'(4);
  localparam logic [MSZ_W-1:0]  MARKER_MIN      = MSZ_W'(1);
  localparam logic [MSZ_W-1:0]  MARKER_MAX      = MSZ_W'(8);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_MARK  = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OOM        = 2'd1,
    ST_NOT_LATEST = 2'd2,
    ST_STACK      = 2'd3
  } status_t;

endpackage

// ===== rtl/msa_req_if.sv =====
interface msa_req_if;
  logic                        valid;
  logic                        ready;
  msa_pkg::req_kind_t          req_type;
  logic [msa_pkg::OFS_W-1:0]   alloc_size;
  logic [msa_pkg::ADDR_W-1:0]  marker_address;

  modport source (output valid, req_type, alloc_size, marker_address, input ready);
  modport sink   (input valid, req_type, alloc_size, marker_address, output ready);
endinterface

// ===== rtl/msa_rsp_if.sv =====
interface msa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [msa_pkg::ADDR_W-1:0]  address;
  msa_pkg::status_t            status;
  logic [msa_pkg::OFS_W-1:0]   used_bytes;

  modport source (output valid, address, status, used_bytes, input ready);
  modport sink   (input valid, address, status, used_bytes, output ready);
endinterface

// ===== rtl/marker_stack_allocator.sv =====
// The result word is registered and valid in the cycle after the request is accepted.
// One request per cycle while the result is taken; a successful free holds off the next
//   request until the restored marker comes back from the saved-marker RAM read.
// Output register decouples the sides: a new request is taken while the result is taken.
// Reset (rst, synchronous): clears top, latest marker, depth and result valid, and loads
//   the register defaults. The saved-marker RAM is not cleared; it is read only after a push.
module marker_stack_allocator (
  input  logic                          clk,
  input  logic                          rst,
  msa_req_if.sink                       req,
  msa_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msa_pkg::PADDR_W-1:0]   paddr,
  input  logic [msa_pkg::PDATA_W-1:0]   pwdata,
  output logic [msa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t                          state;
  logic [msa_pkg::ADDR_W-1:0]      arena_base;
  logic [msa_pkg::OFS_W-1:0]       arena_size;
  logic [msa_pkg::MSZ_W-1:0]       marker_size;

  logic [msa_pkg::OFS_W-1:0]       top;
  logic [msa_pkg::OFS_W-1:0]       latest;
  logic [msa_pkg::DEPTH_W-1:0]     depth;

  logic                            rsp_valid;
  logic [msa_pkg::ADDR_W-1:0]      rsp_address;
  msa_pkg::status_t                rsp_status;
  logic [msa_pkg::OFS_W-1:0]       rsp_used;

  logic [msa_pkg::OFS_W-1:0]       top_next;
  logic [msa_pkg::OFS_W-1:0]       latest_next;
  logic [msa_pkg::DEPTH_W-1:0]     depth_next;
  logic [msa_pkg::ADDR_W-1:0]      addr_next;
  msa_pkg::status_t                status_next;
  logic                            push;
  logic                            pop;

  logic                            accept;
  logic                            cfg_wr;
  logic [msa_pkg::OFS_W-1:0]       limit;
  logic [msa_pkg::MSZ_W-1:0]       msize;
  logic [msa_pkg::OFS_W-1:0]       req_sz;
  logic [msa_pkg::OFS_W:0]         top_sum;
  logic                            fits;
  logic [msa_pkg::ADDR_W-1:0]      top_addr;
  logic [msa_pkg::ADDR_W-1:0]      mark_addr;
  logic [msa_pkg::DEPTH_W-1:0]     depth_dec;
  logic [msa_pkg::OFS_W-1:0]       ram_rdata;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_base  <= msa_pkg::ARENA_BASE_RST;
      arena_size  <= msa_pkg::ARENA_SIZE_RST;
      marker_size <= msa_pkg::MARKER_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        msa_pkg::REG_ARENA_BASE:  arena_base  <= pwdata;
        msa_pkg::REG_ARENA_SIZE:  arena_size  <= pwdata[msa_pkg::OFS_W-1:0];
        msa_pkg::REG_MARKER_SIZE: marker_size <= pwdata[msa_pkg::MSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      msa_pkg::REG_ARENA_BASE:  prdata = arena_base;
      msa_pkg::REG_ARENA_SIZE:  prdata = msa_pkg::PDATA_W'(arena_size);
      msa_pkg::REG_MARKER_SIZE: prdata = msa_pkg::PDATA_W'(marker_size);
      default:                  prdata = '0;
    endcase
  end

  // request decode
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign limit = (arena_size > msa_pkg::OFS_W'(msa_pkg::ARENA_BYTES))
               ? msa_pkg::OFS_W'(msa_pkg::ARENA_BYTES) : arena_size;

  always_comb begin
    priority if (marker_size < msa_pkg::MARKER_MIN) begin
      msize = msa_pkg::MARKER_MIN;
    end else if (marker_size > msa_pkg::MARKER_MAX) begin
      msize = msa_pkg::MARKER_MAX;
    end else begin
      msize = marker_size;
    end
  end

  assign req_sz    = (req.req_type == msa_pkg::REQ_MARK) ? msa_pkg::OFS_W'(msize)
                                                         : req.alloc_size;
  assign top_sum   = {1'b0, top} + {1'b0, req_sz};
  assign fits      = top_sum <= {1'b0, limit};
  assign top_addr  = arena_base + msa_pkg::ADDR_W'(top);
  assign mark_addr = arena_base + msa_pkg::ADDR_W'(latest);
  assign depth_dec = depth - msa_pkg::DEPTH_W'(1);

  always_comb begin
    top_next    = top;
    latest_next = latest;
    depth_next  = depth;
    addr_next   = '0;
    status_next = msa_pkg::ST_OK;
    push        = 1'b0;
    pop         = 1'b0;
    unique case (req.req_type)
      msa_pkg::REQ_ALLOC: begin
        if (!fits) begin
          status_next = msa_pkg::ST_OOM;
        end else begin
          addr_next = top_addr;
          top_next  = top_sum[msa_pkg::OFS_W-1:0];
        end
      end
      msa_pkg::REQ_MARK: begin
        if (depth == msa_pkg::DEPTH_W'(msa_pkg::MAX_MARKERS)) begin
          status_next = msa_pkg::ST_STACK;
        end else if (!fits) begin
          status_next = msa_pkg::ST_OOM;
        end else begin
          push        = 1'b1;
          latest_next = top;
          depth_next  = depth + msa_pkg::DEPTH_W'(1);
          addr_next   = top_addr;
          top_next    = top_sum[msa_pkg::OFS_W-1:0];
        end
      end
      msa_pkg::REQ_FREE: begin
        if (depth == '0) begin
          status_next = msa_pkg::ST_STACK;
        end else if (req.marker_address != mark_addr) begin
          status_next = msa_pkg::ST_NOT_LATEST;
        end else begin
          pop        = 1'b1;
          top_next   = latest;
          depth_next = depth_dec;
        end
      end
      msa_pkg::REQ_CLEAR: begin
        top_next    = '0;
        latest_next = '0;
        depth_next  = '0;
      end
    endcase
  end

  // saved markers: push writes at depth, pop reads at depth - 1
  msa_ram #(
    .WIDTH (msa_pkg::OFS_W),
    .DEPTH (msa_pkg::MAX_MARKERS)
  ) u_stack (
    .clk   (clk),
    .we    (accept && push),
    .waddr (depth[msa_pkg::STK_AW-1:0]),
    .wdata (latest),
    .re    (accept && pop),
    .raddr (depth_dec[msa_pkg::STK_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      top       <= '0;
      latest    <= '0;
      depth     <= '0;
    end else begin
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_address <= addr_next;
            rsp_status  <= status_next;
            rsp_used    <= top_next;
            top         <= top_next;
            latest      <= latest_next;
            depth       <= depth_next;
            if (pop) begin
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          latest <= ram_rdata;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.address    = rsp_address;
  assign rsp.status     = rsp_status;
  assign rsp.used_bytes = rsp_used;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= msa_pkg::DEPTH_W'(msa_pkg::MAX_MARKERS))
    else $error("marker depth beyond stack");

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= msa_pkg::OFS_W'(msa_pkg::ARENA_BYTES))
    else $error("top beyond arena");

  a_pop_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> !req.ready)
    else $error("request taken during marker restore");

  a_pop_seq: assert property (@(posedge clk) disable iff (rst)
    accept && pop |=> state == S_POP && rsp_valid && rsp_status == msa_pkg::ST_OK)
    else $error("free did not enter marker restore");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != msa_pkg::ST_OK |-> rsp_address == '0)
    else $error("failed word carries an address");
`endif

endmodule

// ===== rtl/msa_ram.sv =====
module msa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
